### hw/rtl/rau_pkg.sv
// Shared types and operation codes for the rational arithmetic unit.
package rau_pkg;

  localparam logic [3:0] KIND_ADD = 4'd0;
  localparam logic [3:0] KIND_SUB = 4'd1;
  localparam logic [3:0] KIND_MUL = 4'd2;
  localparam logic [3:0] KIND_DIV = 4'd3;
  localparam logic [3:0] KIND_NEG = 4'd4;
  localparam logic [3:0] KIND_EQ  = 4'd5;
  localparam logic [3:0] KIND_NE  = 4'd6;
  localparam logic [3:0] KIND_LT  = 4'd7;
  localparam logic [3:0] KIND_GT  = 4'd8;
  localparam logic [3:0] KIND_LE  = 4'd9;
  localparam logic [3:0] KIND_GE  = 4'd10;
  localparam logic [3:0] KIND_RED = 4'd11;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Magnitudes of products and sums fit in 33 bits.
  localparam int MagW = 33;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] res_num;
    logic [14:0]        res_den;
    logic               truth;
    logic [1:0]         status;
  } out_beat_t;

  // Datapath commands.
  typedef struct packed {
    logic load;      // capture operands and normalize
    logic prep;      // form the product / lcm setup terms
    logic gcd_init;  // load gcd unit with x, y
    logic gcd_step;  // one subtract-shift step
    logic div_init;  // start quotient division
    logic div_step;  // one restoring step
    logic fin;       // finish and register the result
    logic [1:0] phase; // 0 lcm gcd or da divide, 1 db divide, 2 reduce gcd, 3 reduce divide
  } rau_cmd_t;

  typedef struct packed {
    logic early;     // result known without iteration
    logic gcd_done;
    logic div_done;
  } rau_sts_t;

endpackage

### hw/rtl/rau_ctrl.sv
// Controller state machine sequencing the rational datapath.
module rau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output rau_pkg::rau_cmd_t cmd,
  input  rau_pkg::rau_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREP  = 4'd1;
  localparam logic [3:0] S_LGI   = 4'd2;
  localparam logic [3:0] S_LG    = 4'd3;
  localparam logic [3:0] S_LDI   = 4'd4;
  localparam logic [3:0] S_LD    = 4'd5;
  localparam logic [3:0] S_COMB  = 4'd6;
  localparam logic [3:0] S_RGI   = 4'd7;
  localparam logic [3:0] S_RG    = 4'd8;
  localparam logic [3:0] S_RDI   = 4'd9;
  localparam logic [3:0] S_RD    = 4'd10;
  localparam logic [3:0] S_RDI2  = 4'd11;
  localparam logic [3:0] S_RD2   = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;
  localparam logic [3:0] S_LDI2  = 4'd14;
  localparam logic [3:0] S_LD2   = 4'd15;

  logic [3:0] state, state_next;
  logic       full, full_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = full;

  always_comb begin
    cmd = '0;
    state_next = state;
    full_next = full && out_stall;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (sts.early) state_next = S_FIN;
        else if (sts.gcd_done) state_next = S_LGI;
        else state_next = S_RGI;
      end
      S_LGI: begin
        cmd.gcd_init = 1'b1; cmd.phase = 2'd0; state_next = S_LG;
      end
      S_LG: begin
        cmd.gcd_step = 1'b1; cmd.phase = 2'd0;
        if (sts.gcd_done) state_next = S_LDI;
      end
      S_LDI: begin
        cmd.div_init = 1'b1; cmd.phase = 2'd1; state_next = S_LD;
      end
      S_LD: begin
        cmd.div_step = 1'b1; cmd.phase = 2'd1;
        if (sts.div_done) state_next = S_LDI2;
      end
      S_LDI2: begin
        cmd.div_init = 1'b1; cmd.phase = 2'd0; state_next = S_LD2;
      end
      S_LD2: begin
        cmd.div_step = 1'b1; cmd.phase = 2'd0;
        if (sts.div_done) state_next = S_COMB;
      end
      S_COMB: begin
        cmd.prep = 1'b1; cmd.phase = 2'd1;
        state_next = sts.early ? S_FIN : S_RGI;
      end
      S_RGI: begin
        cmd.gcd_init = 1'b1; cmd.phase = 2'd2; state_next = S_RG;
      end
      S_RG: begin
        cmd.gcd_step = 1'b1; cmd.phase = 2'd2;
        if (sts.gcd_done) state_next = S_RDI;
      end
      S_RDI: begin
        cmd.div_init = 1'b1; cmd.phase = 2'd2; state_next = S_RD;
      end
      S_RD: begin
        cmd.div_step = 1'b1; cmd.phase = 2'd2;
        if (sts.div_done) state_next = S_RDI2;
      end
      S_RDI2: begin
        cmd.div_init = 1'b1; cmd.phase = 2'd3; state_next = S_RD2;
      end
      S_RD2: begin
        cmd.div_step = 1'b1; cmd.phase = 2'd3;
        if (sts.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (!full || !out_stall) begin
          cmd.fin = 1'b1;
          full_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      full <= 1'b0;
    end else begin
      state <= state_next;
      full <= full_next;
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_fin_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!full || !out_stall)) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_PREP)) else $error("load not followed by prep");
`endif

endmodule

### hw/rtl/rau_dp.sv
// Datapath: operand normalization, products, gcd unit and serial divider.
module rau_dp #(
  parameter int WIDTH = 16
) (
  input  logic              clk,
  input  rau_pkg::in_beat_t in_beat,
  input  rau_pkg::rau_cmd_t cmd,
  output rau_pkg::rau_sts_t sts,
  output rau_pkg::out_beat_t out_beat
);

  localparam int M = rau_pkg::MagW;
  localparam int WE = (WIDTH > 16) ? 16 : WIDTH;
  localparam logic [M-1:0] MaxP = M'((64'd1 << (WE - 1)) - 64'd1);

  logic [3:0]         kind;
  logic signed [16:0] na, da, nb, db;
  logic               zero_err;
  // Fraction under reduction: sign and magnitudes.
  logic               rneg;
  logic [M-1:0]       rnum, rden;
  logic [M-1:0]       gx, gy;
  logic [5:0]         gshift;
  logic [M-1:0]       dq, drem, dvs;
  logic [M-1:0]       dnum;
  logic [5:0]         dcnt;
  logic [M-1:0]       gval;
  logic [M:0]         dtrial;
  logic               is_cmp;
  logic               early;
  rau_pkg::out_beat_t early_beat;
  logic               lcm_need;

  logic signed [33:0] xa, xb, pm, pd, pl, pr, pl_den;
  logic signed [16:0] qa, qb;
  logic signed [34:0] sum;
  logic               tr;
  logic signed [16:0] na_n, da_n, nb_n, db_n;

  always_comb begin
    na_n = {in_beat.a_num[15], in_beat.a_num};
    da_n = {in_beat.a_den[15], in_beat.a_den};
    nb_n = {in_beat.b_num[15], in_beat.b_num};
    db_n = {in_beat.b_den[15], in_beat.b_den};
    if (da_n < 0) begin na_n = -na_n; da_n = -da_n; end
    if (db_n < 0) begin nb_n = -nb_n; db_n = -db_n; end
  end

  // For add and subtract, rden holds db/g and dq holds da/g in the combine
  // cycle, so the sum is formed over l = da*(db/g).
  always_comb begin
    xa = 34'(na) * 34'(db);
    xb = 34'(nb) * 34'(da);
    pm = 34'(na) * 34'(nb);
    pd = 34'(da) * 34'(db);
    qa = $signed({1'b0, dq[15:0]});
    qb = $signed({1'b0, rden[15:0]});
    pl = 34'(na) * 34'(qb);
    pr = 34'(nb) * 34'(qa);
    pl_den = 34'(da) * 34'(qb);
    sum = (kind == rau_pkg::KIND_ADD) ? 35'(pl) + 35'(pr) : 35'(pl) - 35'(pr);
    tr = 1'b0;
    case (kind)
      rau_pkg::KIND_EQ: tr = (xa == xb);
      rau_pkg::KIND_NE: tr = (xa != xb);
      rau_pkg::KIND_LT: tr = (xa < xb);
      rau_pkg::KIND_GT: tr = (xa > xb);
      rau_pkg::KIND_LE: tr = (xa <= xb);
      default:          tr = (xa >= xb);
    endcase
    is_cmp = (kind >= rau_pkg::KIND_EQ) && (kind <= rau_pkg::KIND_GE);
    early = (kind > rau_pkg::KIND_RED) || zero_err || is_cmp;
    lcm_need = !early && (kind == rau_pkg::KIND_ADD || kind == rau_pkg::KIND_SUB);
    early_beat = '{res_num: '0, res_den: 15'd1, truth: 1'b0, status: rau_pkg::ST_OK};
    if (kind <= rau_pkg::KIND_RED) begin
      if (zero_err) early_beat.status = rau_pkg::ST_ZERO;
      else if (is_cmp) early_beat.truth = tr;
    end
  end

  always_comb begin
    gval = gx << gshift;
    dtrial = {drem, dnum[M-1]};
    sts.early = early;
    sts.gcd_done = (cmd.prep && cmd.phase == 2'd0) ? lcm_need : (gy == '0);
    sts.div_done = (dcnt == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_beat.kind;
      na <= na_n; da <= da_n; nb <= nb_n; db <= db_n;
      zero_err <= (in_beat.a_den == '0) ||
                  (!(in_beat.kind == rau_pkg::KIND_NEG ||
                     in_beat.kind == rau_pkg::KIND_RED) && in_beat.b_den == '0) ||
                  (in_beat.kind == rau_pkg::KIND_DIV && in_beat.b_num == '0);
    end
    if (cmd.prep && cmd.phase == 2'd0) begin
      case (kind)
        rau_pkg::KIND_MUL: begin
          rneg <= pm < 0;
          rnum <= M'(pm < 0 ? -pm : pm);
          rden <= M'(pd);
        end
        rau_pkg::KIND_DIV: begin
          rneg <= (xa < 0) ^ (xb < 0);
          rnum <= M'(xa < 0 ? -xa : xa);
          rden <= M'(xb < 0 ? -xb : xb);
        end
        rau_pkg::KIND_NEG: begin
          rneg <= !(na < 0);
          rnum <= M'(na < 0 ? -na : na);
          rden <= M'(da);
        end
        rau_pkg::KIND_RED: begin
          rneg <= na < 0;
          rnum <= M'(na < 0 ? -na : na);
          rden <= M'(da);
        end
        default: ;
      endcase
    end
    if (cmd.prep && cmd.phase == 2'd1) begin
      rneg <= sum < 0;
      rnum <= M'(sum < 0 ? -sum : sum);
      rden <= M'(pl_den);
    end
    if (cmd.gcd_init) begin
      gshift <= '0;
      if (cmd.phase == 2'd0) begin
        gx <= M'(da); gy <= M'(db);
      end else begin
        gx <= rnum; gy <= rden;
      end
    end
    if (cmd.gcd_step && gy != '0) begin
      if (gx == '0) begin
        gx <= gy; gy <= '0;
      end else if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; gshift <= gshift + 6'd1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
    if (cmd.div_init) begin
      dcnt <= 6'(M);
      dq <= '0; drem <= '0;
      dvs <= gval;
      unique case (cmd.phase)
        2'd0:    begin dnum <= M'(da); rden <= dq; end
        2'd1:    dnum <= M'(db);
        2'd2:    dnum <= rnum;
        default: begin dnum <= rden; rnum <= dq; end
      endcase
    end
    if (cmd.div_step && dcnt != '0) begin
      dnum <= dnum << 1;
      if (dtrial >= {1'b0, dvs}) begin
        drem <= M'(dtrial - {1'b0, dvs}); dq <= {dq[M-2:0], 1'b1};
      end else begin
        drem <= dtrial[M-1:0]; dq <= {dq[M-2:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
    if (cmd.fin) begin
      if (early) begin
        out_beat <= early_beat;
      end else if (rnum == '0) begin
        out_beat <= '{res_num: '0, res_den: 15'd1, truth: 1'b0, status: rau_pkg::ST_OK};
      end else if ((rneg ? (rnum > MaxP + M'(1)) : (rnum > MaxP)) || dq > MaxP) begin
        out_beat <= '{res_num: '0, res_den: 15'd1, truth: 1'b0, status: rau_pkg::ST_OVF};
      end else begin
        out_beat.res_num <= rneg ? -16'(rnum) : 16'(rnum);
        out_beat.res_den <= 15'(dq);
        out_beat.truth <= 1'b0;
        out_beat.status <= rau_pkg::ST_OK;
      end
    end
  end

endmodule

### hw/rtl/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit.
// One beat is worked at a time. The time to a result is set by the binary
// gcd unit (one subtract-shift step a cycle) and the 33-step serial divider,
// which runs twice to find both lcm cofactors of add and subtract and twice to
// reduce the result. Comparisons, unused kinds, zero denominators and division
// by zero finish without iteration. A result beat waits in an output register
// while the next beat is taken and worked; that next result then waits until
// the register empties.
module rational_arithmetic_unit_core #(
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rau_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rau_pkg::out_beat_t out_data
);

  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk, .in_beat(in_data), .cmd, .sts, .out_beat(out_data)
  );

endmodule
